[sv/lsc_pkg.sv]
// Shared types and constants for the sound slot cache.
// Holds the controller state enum and the command and status structs.
// Used by lsc_ctrl, lsc_datapath and lru_sound_slot_cache.
package lsc_pkg;

   localparam int SLOTS_DEF    = 44;
   localparam int KEY_BITS_DEF = 32;
   localparam int ID_W         = 32;
   localparam int STAMP_W      = 32;
   localparam int SLOT_W       = 6;
   localparam logic [SLOT_W-1:0] CHANNEL_BASE = 6'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_hold;
   } status_type;

endpackage

[sv/lsc_ctrl.sv]
// Controller state machine for the sound slot cache.
// Sequences accept, slot scan and commit; depends on lsc_pkg.
module lsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lsc_pkg::status_type  status,
   output lsc_pkg::cmd_type     cmd
);
   import lsc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!status.rsp_hold) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/lsc_datapath.sv]
// Datapath of the sound slot cache: key and stamp memories, valid bits,
// use counter, scan pipeline with hit and victim search, result register.
// Depends on lsc_pkg; driven by lsc_ctrl commands.
module lsc_datapath #(
   parameter int SLOTS    = lsc_pkg::SLOTS_DEF,
   parameter int KEY_BITS = lsc_pkg::KEY_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsc_pkg::cmd_type              cmd,
   output lsc_pkg::status_type           status,
   input  logic [lsc_pkg::ID_W-1:0]      req_sound_id,
   input  logic                          req_load_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_played,
   output logic [lsc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [lsc_pkg::SLOT_W-1:0]    rsp_channel,
   output logic                          rsp_evicted,
   output logic [lsc_pkg::ID_W-1:0]      rsp_evicted_id
);
   import lsc_pkg::*;

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS = $clog2(SLOTS + 1);

   logic [KEY_BITS-1:0] key_mem [SLOTS];
   logic [STAMP_W-1:0]  stamp_mem [SLOTS];

   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [STAMP_W-1:0]  counter_ff, counter_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                ok_ff, ok_in;
   logic [STAMP_W-1:0]  bound_ff, bound_in;
   logic [CNT_BITS-1:0] rd_cnt_ff, rd_cnt_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_BITS-1:0] cmp_idx_ff, cmp_idx_in;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [STAMP_W-1:0]  stamp_rd_ff;
   logic                hit_ff, hit_in;
   logic [IDX_BITS-1:0] hit_idx_ff, hit_idx_in;
   logic                empty_ff, empty_in;
   logic [IDX_BITS-1:0] empty_idx_ff, empty_idx_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   logic [KEY_BITS-1:0] best_key_ff, best_key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_played_ff, rsp_played_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [SLOT_W-1:0]   rsp_channel_ff, rsp_channel_in;
   logic                rsp_evicted_ff, rsp_evicted_in;
   logic [ID_W-1:0]     rsp_evicted_id_ff, rsp_evicted_id_in;

   logic                rd_en;
   logic [IDX_BITS-1:0] rd_idx;
   logic                ent_valid;
   logic                key_match;
   logic                older;
   logic                take_best;
   logic [IDX_BITS-1:0] vic_idx;
   logic [IDX_BITS-1:0] wr_idx;
   logic                do_load;
   logic                do_stamp;
   logic                played;

   always_comb begin
      rd_en     = cmd.scan && (rd_cnt_ff < CNT_BITS'(SLOTS));
      rd_idx    = rd_cnt_ff[IDX_BITS-1:0];
      ent_valid = valid_ff[cmp_idx_ff];
      key_match = cmp_vld_ff && ent_valid && (key_rd_ff == key_ff);
      older     = stamp_rd_ff < bound_ff;
      take_best = cmp_vld_ff && ent_valid && !empty_ff && (older || (cmp_idx_ff == '0));
      vic_idx   = empty_ff ? empty_idx_ff : best_idx_ff;
      wr_idx    = hit_ff ? hit_idx_ff : vic_idx;
      played    = hit_ff || ok_ff;
      do_load   = cmd.commit && !hit_ff && ok_ff;
      do_stamp  = cmd.commit && played;

      status.scan_done = cmp_vld_ff && (cmp_idx_ff == IDX_BITS'(SLOTS - 1));
      status.rsp_hold  = rsp_valid_ff && rsp_stall;

      valid_in     = valid_ff;
      counter_in   = counter_ff;
      key_in       = key_ff;
      ok_in        = ok_ff;
      bound_in     = bound_ff;
      rd_cnt_in    = rd_cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = rd_idx;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      best_idx_in  = best_idx_ff;
      best_key_in  = best_key_ff;

      if (cmd.start) begin
         counter_in  = counter_ff + 1'b1;
         bound_in    = counter_ff + 1'b1;
         key_in      = KEY_BITS'(req_sound_id);
         ok_in       = req_load_ok;
         rd_cnt_in   = '0;
         hit_in      = 1'b0;
         empty_in    = 1'b0;
         best_idx_in = '0;
      end

      if (rd_en) begin
         rd_cnt_in  = rd_cnt_ff + 1'b1;
         cmp_vld_in = 1'b1;
      end

      if (key_match && !hit_ff) begin
         hit_in     = 1'b1;
         hit_idx_in = cmp_idx_ff;
      end
      if (cmp_vld_ff && !ent_valid && !empty_ff) begin
         empty_in     = 1'b1;
         empty_idx_in = cmp_idx_ff;
      end
      if (take_best) begin
         best_idx_in = cmp_idx_ff;
         best_key_in = key_rd_ff;
         if (older) begin
            bound_in = stamp_rd_ff;
         end
      end

      if (do_load) begin
         valid_in[vic_idx] = 1'b1;
      end

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_hit_in        = rsp_hit_ff;
      rsp_played_in     = rsp_played_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_channel_in    = rsp_channel_ff;
      rsp_evicted_in    = rsp_evicted_ff;
      rsp_evicted_id_in = rsp_evicted_id_ff;
      if (cmd.commit) begin
         rsp_valid_in      = 1'b1;
         rsp_hit_in        = hit_ff;
         rsp_played_in     = played;
         rsp_slot_in       = played ? SLOT_W'(wr_idx) : '0;
         rsp_channel_in    = played ? SLOT_W'(wr_idx) + CHANNEL_BASE : '0;
         rsp_evicted_in    = !hit_ff && ok_ff && !empty_ff;
         rsp_evicted_id_in = (!hit_ff && ok_ff && !empty_ff) ? ID_W'(best_key_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         counter_ff   <= '0;
         rd_cnt_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         rd_cnt_ff    <= rd_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff            <= key_in;
      ok_ff             <= ok_in;
      bound_ff          <= bound_in;
      cmp_idx_ff        <= cmp_idx_in;
      hit_ff            <= hit_in;
      hit_idx_ff        <= hit_idx_in;
      empty_ff          <= empty_in;
      empty_idx_ff      <= empty_idx_in;
      best_idx_ff       <= best_idx_in;
      best_key_ff       <= best_key_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_played_ff     <= rsp_played_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_channel_ff    <= rsp_channel_in;
      rsp_evicted_ff    <= rsp_evicted_in;
      rsp_evicted_id_ff <= rsp_evicted_id_in;
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         key_mem[vic_idx] <= key_ff;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (do_stamp) begin
         stamp_mem[wr_idx] <= counter_ff;
      end
      if (rd_en) begin
         stamp_rd_ff <= stamp_mem[rd_idx];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_played     = rsp_played_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_evicted_id = rsp_evicted_id_ff;

   a_hit_not_evicted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("hit and eviction reported together");

   a_channel_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_played_ff) |-> (rsp_channel_ff == rsp_slot_ff + CHANNEL_BASE))
      else $error("channel does not follow slot");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not load the result word");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CNT_BITS'(SLOTS))
      else $error("scan counter ran past the last slot");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      do_load |=> valid_ff[$past(vic_idx)])
      else $error("loaded slot not marked valid");

endmodule

[sv/lru_sound_slot_cache.sv]
// Sound slot cache, top level. A request word's result is presented after a
// scan through the key and stamp memories, one slot per cycle. A new word is
// taken only once the last one is committed; the next word is taken while a
// finished result waits on rsp_stall.
// Reset (synchronous) clears all valid bits and the use counter; no sweep.
module lru_sound_slot_cache #(
   parameter int SLOTS    = lsc_pkg::SLOTS_DEF,
   parameter int KEY_BITS = lsc_pkg::KEY_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lsc_pkg::ID_W-1:0]      req_sound_id,
   input  logic                          req_load_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_played,
   output logic [lsc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [lsc_pkg::SLOT_W-1:0]    rsp_channel,
   output logic                          rsp_evicted,
   output logic [lsc_pkg::ID_W-1:0]      rsp_evicted_id
);
   import lsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   lsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lsc_datapath #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sound_id   (req_sound_id),
      .req_load_ok    (req_load_ok),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_played     (rsp_played),
      .rsp_slot       (rsp_slot),
      .rsp_channel    (rsp_channel),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_id (rsp_evicted_id)
   );

endmodule
